[sv/bsdl_pkg.sv]
// Shared types and codes for the bounded sorted deque list.
package bsdl_pkg;

  localparam int unsigned DATA_W = 32;

  // Request opcodes.
  localparam logic [2:0] OP_PUSH_HEAD = 3'd0;
  localparam logic [2:0] OP_PUSH_TAIL = 3'd1;
  localparam logic [2:0] OP_SORTED    = 3'd2;
  localparam logic [2:0] OP_POP_HEAD  = 3'd3;
  localparam logic [2:0] OP_POP_TAIL  = 3'd4;
  localparam logic [2:0] OP_REMOVE    = 3'd5;
  localparam logic [2:0] OP_QUERY     = 3'd6;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  // One request beat.
  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] data_value;
  } req_t;

  // One result beat.
  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     found;
    logic [1:0]               status;
    logic [4:0]               occupancy;
  } rsp_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic [2:0]        op;
    logic [DATA_W-1:0] key;
    logic              ins_en;
    logic              rem_en;
  } cell_ctrl_t;

  // Signals rippling from cell to cell, head to tail.
  typedef struct packed {
    logic              seen;
    logic [DATA_W-1:0] tail;
  } cell_link_t;

endpackage

[sv/bsdl_cell.sv]
// One storage cell of the list: a value, its valid bit and its shift logic.
module bsdl_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  bsdl_pkg::cell_ctrl_t      ctrl,
  input  logic [bsdl_pkg::DATA_W-1:0] left_val,
  input  logic                      left_valid,
  input  logic [bsdl_pkg::DATA_W-1:0] right_val,
  input  logic                      right_valid,
  input  bsdl_pkg::cell_link_t      link_in,
  output bsdl_pkg::cell_link_t      link_out,
  output logic [bsdl_pkg::DATA_W-1:0] val,
  output logic                      valid
);
  import bsdl_pkg::*;

  logic              stop;
  logic              is_last;
  logic [DATA_W-1:0] val_next;
  logic              valid_next;

  // This cell is the last occupied one when its right neighbor is empty.
  assign is_last = valid & ~right_valid;

  // Decide whether this cell is a candidate position for the operation.
  always_comb begin
    case (ctrl.op)
      OP_PUSH_HEAD: stop = 1'b1;
      OP_PUSH_TAIL: stop = ~valid;
      OP_SORTED:    stop = ~valid | ~($signed(val) < $signed(ctrl.key));
      OP_POP_HEAD:  stop = 1'b1;
      OP_POP_TAIL:  stop = is_last;
      OP_REMOVE:    stop = valid & (val == ctrl.key);
      OP_QUERY:     stop = valid & (val == ctrl.key);
      default:      stop = 1'b0;
    endcase
  end

  // Pass the first-match flag and the tail value down the chain.
  assign link_out.seen = link_in.seen | stop;
  assign link_out.tail = link_in.tail | (is_last ? val : '0);

  // Insert shifts toward the tail from the first match; removal shifts toward the head.
  always_comb begin
    val_next   = val;
    valid_next = valid;
    if (ctrl.ins_en) begin
      if (link_in.seen) begin
        val_next   = left_val;
        valid_next = left_valid;
      end else if (stop) begin
        val_next   = ctrl.key;
        valid_next = 1'b1;
      end
    end else if (ctrl.rem_en) begin
      if (link_in.seen | stop) begin
        val_next   = right_val;
        valid_next = right_valid;
      end
    end
  end

  // Value register has no reset; the valid bit does.
  always_ff @(posedge clk) begin
    val <= val_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

[sv/bounded_sorted_deque_list.sv]
// Top level of the bounded sorted deque list built as a chain of cells.
//
//   channel   | direction | handshake             | payload
//   ----------+-----------+-----------------------+---------------------------
//   request   | in        | start, busy           | op, data_value
//   result    | out       | done (one-cycle pulse)| result_value, found,
//             |           |                       | status, occupancy
//
// A request beat is taken on any edge with start high; busy stays low, so a
// new beat may follow every cycle. Its result appears on result with done
// high in the cycle after. All cells update together in the same edge,
// with the first-match flag and tail value rippling through the cell chain.
// Reset clears every valid bit and the entry count at once; no clearing pass.
// The receiver cannot stall: each result is shown for one cycle only.
module bounded_sorted_deque_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  bsdl_pkg::req_t request,
  output logic           done,
  output bsdl_pkg::rsp_t result
);
  import bsdl_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              full;
  logic              empty;
  logic              is_insert;
  logic              is_pop;
  cell_ctrl_t        ctrl;
  cell_link_t        links [CAPACITY+1];
  logic [DATA_W-1:0] cell_val   [CAPACITY];
  logic              cell_valid [CAPACITY];
  rsp_t              rsp_next;
  logic              accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign is_insert = (request.op == OP_PUSH_HEAD) || (request.op == OP_PUSH_TAIL) ||
                     (request.op == OP_SORTED);
  assign is_pop    = (request.op == OP_POP_HEAD) || (request.op == OP_POP_TAIL);

  // Broadcast the operation to all cells.
  always_comb begin
    ctrl.op     = request.op;
    ctrl.key    = request.data_value;
    ctrl.ins_en = accept & is_insert & ~full;
    ctrl.rem_en = accept & ((is_pop & ~empty) | (request.op == OP_REMOVE));
  end

  assign links[0].seen = 1'b0;
  assign links[0].tail = '0;

  // The cell chain, head at index zero.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] lv;
    logic              lvalid;
    logic [DATA_W-1:0] rv;
    logic              rvalid;

    if (i == 0) begin : g_head
      assign lv     = '0;
      assign lvalid = 1'b0;
    end else begin : g_mid_l
      assign lv     = cell_val[i-1];
      assign lvalid = cell_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rv     = '0;
      assign rvalid = 1'b0;
    end else begin : g_mid_r
      assign rv     = cell_val[i+1];
      assign rvalid = cell_valid[i+1];
    end

    bsdl_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_val    (lv),
      .left_valid  (lvalid),
      .right_val   (rv),
      .right_valid (rvalid),
      .link_in     (links[i]),
      .link_out    (links[i+1]),
      .val         (cell_val[i]),
      .valid       (cell_valid[i])
    );
  end

  // Result fields and the new entry count.
  always_comb begin
    rsp_next   = '0;
    count_next = count;
    case (request.op)
      OP_PUSH_HEAD, OP_PUSH_TAIL, OP_SORTED: begin
        if (full) begin
          rsp_next.status = STAT_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      OP_POP_HEAD, OP_POP_TAIL: begin
        if (empty) begin
          rsp_next.status = STAT_EMPTY;
        end else begin
          count_next = count - 1'b1;
          rsp_next.result_value = (request.op == OP_POP_HEAD) ? cell_val[0]
                                                              : links[CAPACITY].tail;
        end
      end
      OP_REMOVE: begin
        if (links[CAPACITY].seen) begin
          rsp_next.found = 1'b1;
          count_next     = count - 1'b1;
        end else begin
          rsp_next.status = STAT_NOT_FOUND;
        end
      end
      OP_QUERY: begin
        rsp_next.found = links[CAPACITY].seen;
      end
      default: begin
        rsp_next = '0;
      end
    endcase
    rsp_next.occupancy = 5'(count_next);
  end

  // Entry count and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= rsp_next;
    end
  end

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the bounded sorted deque list: random command stream vs. a list model.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsdl_pkg::*;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned RANDOM_ITEMS = 520;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned POOL_SIZE    = 12;

  // The one opcode that the block ignores.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam logic [2:0] ALL_OPS [8] = '{OP_PUSH_HEAD, OP_PUSH_TAIL, OP_SORTED, OP_POP_HEAD,
                                         OP_POP_TAIL, OP_REMOVE, OP_QUERY, OP_UNUSED};

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  // Episode flavors of the random stream.
  localparam int unsigned MODE_FILL  = 0;
  localparam int unsigned MODE_DRAIN = 1;
  localparam int unsigned MODE_MIXED = 2;

  // One command waiting to be driven, with its idle gap and drain request.
  typedef struct {
    req_t        beat;
    int unsigned gap;
    bit          drain;
  } cmd_slot_t;

  logic clk     = 1'b0;
  logic rst     = 1'b1;
  logic start   = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  rsp_t result;

  // Model of the stored sequence, head at index 0.
  logic signed [DATA_W-1:0] list_model [$];
  rsp_t                     due_rsp_q  [$];
  cmd_slot_t                cmd_q      [$];
  logic signed [DATA_W-1:0] value_pool [POOL_SIZE];

  int unsigned cmd_total    = 0;
  int unsigned accepted_cnt = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  int          in_flight    = 0;
  rsp_t        want_rsp;

  bounded_sorted_deque_list #(
    .CAPACITY (CAPACITY)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #1ns clk = ~clk;

  // Index of the first entry equal to the value, or -1 when there is none.
  function automatic int find_entry(logic signed [DATA_W-1:0] value);
    for (int i = 0; i < list_model.size(); i++) begin
      if (list_model[i] == value) return i;
    end
    return -1;
  endfunction

  // Applies one request to the list model and returns the result it must produce.
  function automatic rsp_t apply_to_model(req_t beat);
    rsp_t rsp;
    int   pos;
    rsp = '0;
    case (beat.op)
      OP_PUSH_HEAD, OP_PUSH_TAIL, OP_SORTED: begin
        if (list_model.size() >= CAPACITY) begin
          rsp.status = STAT_FULL;
        end else begin
          if (beat.op == OP_PUSH_HEAD) begin
            pos = 0;
          end else if (beat.op == OP_PUSH_TAIL) begin
            pos = list_model.size();
          end else begin
            // Goes in front of the first entry not less than the value (signed).
            pos = 0;
            while (pos < list_model.size() && list_model[pos] < beat.data_value) pos++;
          end
          list_model.insert(pos, beat.data_value);
        end
      end
      OP_POP_HEAD, OP_POP_TAIL: begin
        if (list_model.size() == 0) begin
          rsp.status = STAT_EMPTY;
        end else if (beat.op == OP_POP_HEAD) begin
          rsp.result_value = list_model.pop_front();
        end else begin
          rsp.result_value = list_model.pop_back();
        end
      end
      OP_REMOVE: begin
        pos = find_entry(beat.data_value);
        if (pos >= 0) begin
          list_model.delete(pos);
          rsp.found = 1'b1;
        end else begin
          rsp.status = STAT_NOT_FOUND;
        end
      end
      OP_QUERY: begin
        rsp.found = (find_entry(beat.data_value) >= 0);
      end
      default: ;
    endcase
    rsp.occupancy = 5'(list_model.size());
    return rsp;
  endfunction

  // Idle cycles ahead of a command: mostly none, some short, a few long.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mostly values from the episode pool so that removes and queries hit.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 80) return $urandom;
    if (roll < 90) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MAX;
        1:       return VAL_MIN;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $signed($urandom_range(0, 20)) - 10;
  endfunction

  function automatic logic [2:0] pick_op(int unsigned mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (mode == MODE_FILL) begin
      if (roll < 35) return OP_SORTED;
      if (roll < 55) return OP_PUSH_HEAD;
      if (roll < 75) return OP_PUSH_TAIL;
      if (roll < 85) return OP_QUERY;
      if (roll < 92) return OP_REMOVE;
      if (roll < 97) return (roll[0]) ? OP_POP_HEAD : OP_POP_TAIL;
      return OP_UNUSED;
    end
    if (mode == MODE_DRAIN) begin
      if (roll < 30) return OP_POP_HEAD;
      if (roll < 55) return OP_POP_TAIL;
      if (roll < 80) return OP_REMOVE;
      if (roll < 90) return OP_QUERY;
      if (roll < 97) return OP_SORTED;
      return OP_UNUSED;
    end
    return ALL_OPS[$urandom_range(0, 7)];
  endfunction

  task automatic refill_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(0, 3))
        0:       value_pool[i] = $urandom;
        1:       value_pool[i] = (i[0]) ? VAL_MAX - i : VAL_MIN + i;
        default: value_pool[i] = $signed($urandom_range(0, 40)) - 20;
      endcase
    end
  endtask

  task automatic add_cmd(logic [2:0] op, logic signed [DATA_W-1:0] value,
                         int unsigned gap, bit drain);
    cmd_slot_t slot;
    slot.beat.op         = op;
    slot.beat.data_value = value;
    slot.gap             = gap;
    slot.drain           = drain;
    cmd_q.push_back(slot);
    cmd_total++;
  endtask

  // Driver: takes the next command once the current beat has been accepted.
  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      request   <= '0;
      in_flight = 0;
    end else begin
      if (start && !busy) begin
        due_rsp_q.push_back(apply_to_model(request));
        in_flight++;
        accepted_cnt++;
      end
      if (done) in_flight--;
      if (!start || !busy) begin
        if (cmd_q.size() == 0) begin
          start <= 1'b0;
        end else if (cmd_q[0].gap > 0) begin
          cmd_q[0].gap = cmd_q[0].gap - 1;
          start <= 1'b0;
        end else if (cmd_q[0].drain && in_flight != 0) begin
          start <= 1'b0;
        end else begin
          request <= cmd_q[0].beat;
          start   <= 1'b1;
          void'(cmd_q.pop_front());
        end
      end
    end
  end

  // Monitor: every result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (due_rsp_q.size() == 0) begin
        mismatches++;
        $error("result beat arrived with no request outstanding");
      end else begin
        want_rsp = due_rsp_q.pop_front();
        if (result.result_value !== want_rsp.result_value) begin
          mismatches++;
          $error("result_value: expected %0d, got %0d", want_rsp.result_value,
                 result.result_value);
        end
        if (result.found !== want_rsp.found) begin
          mismatches++;
          $error("found: expected %0d, got %0d", want_rsp.found, result.found);
        end
        if (result.status !== want_rsp.status) begin
          mismatches++;
          $error("status: expected %0d, got %0d", want_rsp.status, result.status);
        end
        if (result.occupancy !== want_rsp.occupancy) begin
          mismatches++;
          $error("occupancy: expected %0d, got %0d", want_rsp.occupancy, result.occupancy);
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no beat moving either way.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Stimulus: a directed opening, then random fill, drain and mixed episodes.
  initial begin : stimulus
    int unsigned produced;
    int unsigned episode;
    int unsigned len;
    int unsigned mode;
    bit          calm;

    // Empty list: pops, a failed remove and a failed query.
    add_cmd(OP_POP_HEAD, VAL_MAX, 0, 1'b0);
    add_cmd(OP_POP_TAIL, VAL_MIN, 0, 1'b0);
    add_cmd(OP_REMOVE, 7, 0, 1'b0);
    add_cmd(OP_QUERY, 7, 0, 1'b0);
    // Extremes at both ends, then sorted inserts around them.
    add_cmd(OP_PUSH_HEAD, VAL_MAX, 0, 1'b0);
    add_cmd(OP_PUSH_TAIL, VAL_MIN, 0, 1'b0);
    add_cmd(OP_SORTED, 0, 0, 1'b0);
    add_cmd(OP_SORTED, -1, 1, 1'b0);
    add_cmd(OP_SORTED, VAL_MIN, 0, 1'b0);
    add_cmd(OP_QUERY, VAL_MIN, 0, 1'b0);
    add_cmd(OP_QUERY, 5, 0, 1'b0);
    add_cmd(OP_REMOVE, 0, 0, 1'b0);
    add_cmd(OP_REMOVE, 5, 2, 1'b0);
    add_cmd(OP_UNUSED, -1, 0, 1'b0);
    // Pop everything from both ends and once more past empty.
    add_cmd(OP_POP_HEAD, 0, 0, 1'b0);
    add_cmd(OP_POP_TAIL, 0, 0, 1'b0);
    add_cmd(OP_POP_TAIL, 0, 0, 1'b0);
    add_cmd(OP_POP_HEAD, 0, 0, 1'b0);
    add_cmd(OP_POP_HEAD, 0, 0, 1'b0);

    produced = 0;
    episode  = 0;
    while (produced < RANDOM_ITEMS) begin
      refill_pool();
      mode = episode % 3;
      len  = (mode == MODE_MIXED) ? $urandom_range(10, 30) : $urandom_range(20, 28);
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        // The first episode, and some others, start only once every result is back.
        add_cmd(pick_op(mode), pick_value(), pick_gap(calm),
                (i == 0) && (episode == 0 || $urandom_range(0, 5) == 0));
      end
      produced += len;
      episode++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cnt < cmd_total) @(negedge clk);
    while (due_rsp_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/bsdl_pkg.sv
sv/bsdl_cell.sv
sv/bounded_sorted_deque_list.sv
tb/tb_top.sv
